// ----- src/rlr_pkg.sv -----
`default_nettype none

package rlr_pkg;

  // pixel channel width and the quotient bits resolved by the divider chain
  localparam int unsigned PixW     = 8;
  localparam int unsigned NumCh    = 3;
  localparam int unsigned NumCells = PixW;
  // front stage, one stage per quotient bit, output stage
  localparam int unsigned NumStg   = NumCells + 2;
  localparam int unsigned CfgIdxW  = 2;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegInLow   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegInHigh  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOutLow  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOutHigh = 2'd3;

  // reset levels
  localparam logic [PixW-1:0] RstInLow   = 8'd130;
  localparam logic [PixW-1:0] RstInHigh  = 8'd130;
  localparam logic [PixW-1:0] RstOutLow  = 8'd0;
  localparam logic [PixW-1:0] RstOutHigh = 8'd255;

  // where a channel value falls against the input levels
  typedef enum logic [1:0] {
    CLS_LOW,
    CLS_HIGH,
    CLS_MID
  } cls_e;

  typedef struct packed {
    logic [PixW-1:0] in_low;
    logic [PixW-1:0] in_high;
    logic [PixW-1:0] out_low;
    logic [PixW-1:0] out_high;
  } cfg_t;

  // data handed from cell to cell for one channel
  typedef struct packed {
    cls_e            cls;
    logic [PixW-1:0] rem;
    logic [PixW-1:0] dvd;
    logic [PixW-1:0] quo;
  } rlr_div_t;

endpackage

`default_nettype wire

// ----- src/rlr_front.sv -----
`default_nettype none

module rlr_front import rlr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire cfg_t            cfg_i,
  input  wire logic [PixW-1:0] pix_i,
  output rlr_div_t             stage_o
);

  cls_e              cls;
  logic [PixW-1:0]   ofs;
  logic [PixW-1:0]   out_mag;
  logic [2*PixW-1:0] prod;
  rlr_div_t          stage_d;
  rlr_div_t          stage_q;

  // classify against the input levels
  always_comb begin
    if (pix_i <= cfg_i.in_low) begin
      cls = CLS_LOW;
    end else if (pix_i >= cfg_i.in_high) begin
      cls = CLS_HIGH;
    end else begin
      cls = CLS_MID;
    end
  end

  // distance above in_low times the size of the output range
  always_comb begin
    ofs = pix_i - cfg_i.in_low;
    if (cfg_i.out_high < cfg_i.out_low) begin
      out_mag = cfg_i.out_low - cfg_i.out_high;
    end else begin
      out_mag = cfg_i.out_high - cfg_i.out_low;
    end
    prod = ofs * out_mag;
  end

  // the upper byte starts as the partial remainder, below the span
  always_comb begin
    stage_d.cls = cls;
    stage_d.rem = prod[2*PixW-1:PixW];
    stage_d.dvd = prod[PixW-1:0];
    stage_d.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- src/rlr_div_cell.sv -----
`default_nettype none

module rlr_div_cell import rlr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire logic [PixW-1:0] span_i,
  input  wire rlr_div_t        stage_i,
  output rlr_div_t             stage_o
);

  logic [PixW:0] trial;
  logic [PixW:0] diff;
  logic          fits;
  rlr_div_t      stage_d;
  rlr_div_t      stage_q;

  // one restoring step: bring down the next dividend bit, try the span
  always_comb begin
    trial = {stage_i.rem, stage_i.dvd[PixW-1]};
    diff  = trial - {1'b0, span_i};
    fits  = (trial >= {1'b0, span_i});
    stage_d.cls = stage_i.cls;
    stage_d.rem = fits ? diff[PixW-1:0] : trial[PixW-1:0];
    stage_d.dvd = {stage_i.dvd[PixW-2:0], 1'b0};
    stage_d.quo = {stage_i.quo[PixW-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- src/rlr_back.sv -----
`default_nettype none

module rlr_back import rlr_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire cfg_t            cfg_i,
  input  wire rlr_div_t        stage_i,
  output logic [PixW-1:0]      pix_o
);

  logic            falling;
  logic [PixW-1:0] step_up;
  logic [PixW-1:0] mid_val;
  logic [PixW-1:0] pix_d;
  logic [PixW-1:0] pix_q;

  // reversed range steps down by the ceiling of the quotient
  always_comb begin
    falling = (cfg_i.out_high < cfg_i.out_low);
    step_up = stage_i.quo + {{(PixW-1){1'b0}}, (stage_i.rem != '0)};
    if (falling) begin
      mid_val = cfg_i.out_low - step_up;
    end else begin
      mid_val = cfg_i.out_low + stage_i.quo;
    end
  end

  // pick the level or the interpolated value
  always_comb begin
    case (stage_i.cls)
      CLS_LOW:  pix_d = cfg_i.out_low;
      CLS_HIGH: pix_d = cfg_i.out_high;
      CLS_MID:  pix_d = mid_val;
      default:  pix_d = cfg_i.out_low;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

// ----- src/rgb_levels_remap.sv -----
// levels remap of one rgb pixel, each channel through its own chain of divider cells
// a pixel moves through the front register, the 8 cell registers, then the back register
// throughput: one pixel per cycle unless stalled; each cell resolves one quotient bit
// stages hand over whenever the next one is empty or moving, so bubbles fill while stalled
// reset: valid bits clear at once, levels return to in 130/130, out 0/255; data is not reset
`default_nettype none

module rgb_levels_remap import rlr_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [PixW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [PixW-1:0]    red_in_i,
  input  wire logic [PixW-1:0]    green_in_i,
  input  wire logic [PixW-1:0]    blue_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [PixW-1:0]         red_out_o,
  output logic [PixW-1:0]         green_out_o,
  output logic [PixW-1:0]         blue_out_o
);

  cfg_t               cfg_q;
  logic [PixW-1:0]    span;
  logic [NumStg-1:0]  vld_q;
  logic [NumStg-1:0]  vld_d;
  logic [NumStg-1:0]  adv;
  logic               in_fire;
  logic [PixW-1:0]    pix_in  [NumCh];
  logic [PixW-1:0]    pix_out [NumCh];
  rlr_div_t           chain   [NumCh][NumCells+1];

  // level registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_low   <= RstInLow;
      cfg_q.in_high  <= RstInHigh;
      cfg_q.out_low  <= RstOutLow;
      cfg_q.out_high <= RstOutHigh;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegInLow:   cfg_q.in_low   <= cfg_wdata_i;
        RegInHigh:  cfg_q.in_high  <= cfg_wdata_i;
        RegOutLow:  cfg_q.out_low  <= cfg_wdata_i;
        RegOutHigh: cfg_q.out_high <= cfg_wdata_i;
        default:    cfg_q          <= cfg_q;
      endcase
    end
  end

  // divisor, at least two whenever a channel lies strictly inside the levels
  assign span = cfg_q.in_high - cfg_q.in_low;

  // a stage moves when it is empty or the stage after it moves
  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int i = NumStg - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  assign in_ready_o = adv[0];
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = in_fire;
    end
    for (int i = 1; i < NumStg; i++) begin
      if (adv[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // per channel datapath
  assign pix_in[0] = red_in_i;
  assign pix_in[1] = green_in_i;
  assign pix_in[2] = blue_in_i;

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    rlr_front u_front (
      .clk_i   (clk_i),
      .en_i    (adv[0]),
      .cfg_i   (cfg_q),
      .pix_i   (pix_in[c]),
      .stage_o (chain[c][0])
    );

    for (genvar j = 0; j < NumCells; j++) begin : g_cell
      rlr_div_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (adv[j+1]),
        .span_i  (span),
        .stage_i (chain[c][j]),
        .stage_o (chain[c][j+1])
      );
    end

    rlr_back u_back (
      .clk_i   (clk_i),
      .en_i    (adv[NumStg-1]),
      .cfg_i   (cfg_q),
      .stage_i (chain[c][NumCells]),
      .pix_o   (pix_out[c])
    );
  end

  // result beat
  assign out_valid_o = vld_q[NumStg-1];
  assign red_out_o   = pix_out[0];
  assign green_out_o = pix_out[1];
  assign blue_out_o  = pix_out[2];

endmodule

`default_nettype wire

// ----- src/rlr_checker.sv -----
`default_nettype none

module rlr_checker import rlr_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            cfg_ready_o,
  input wire logic            in_ready_o,
  input wire logic            out_valid_o,
  input wire logic            out_ready_i,
  input wire logic [PixW-1:0] red_out_o,
  input wire logic [PixW-1:0] green_out_o,
  input wire logic [PixW-1:0] blue_out_o
);

  // a stalled result beat keeps its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(green_out_o) && $stable(blue_out_o))
    else $error("stalled result beat changed");

  // input back-pressure only comes from a blocked output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output free");

  // level writes never wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

  // pipeline comes out of reset empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("output valid right after reset");

endmodule

bind rgb_levels_remap rlr_checker u_rlr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_out_o   (red_out_o),
  .green_out_o (green_out_o),
  .blue_out_o  (blue_out_o)
);

`default_nettype wire

// ----- tb/tb_rgb_levels_remap.sv -----
module tb_rgb_levels_remap;
  import rlr_pkg::*;

  // one remapped pixel as it leaves the block
  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = RegInLow;
  logic [PixW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic [PixW-1:0]    red_in_i    = '0;
  logic [PixW-1:0]    green_in_i  = '0;
  logic [PixW-1:0]    blue_in_i   = '0;
  logic               out_ready_i = 1'b0;
  logic               cfg_ready_o;
  logic               in_ready_o;
  logic               out_valid_o;
  logic [PixW-1:0]    red_out_o;
  logic [PixW-1:0]    green_out_o;
  logic [PixW-1:0]    blue_out_o;

  // shadow of the level registers and the pixels still owed by the block
  cfg_t   lvl_cfg;
  pixel_t remapped_q[$];
  bit     mismatch_seen = 1'b0;
  int     snd_idle_pct  = 24;
  int     rcv_idle_pct  = 86;

  rgb_levels_remap dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop for a hung handshake
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // levels transfer for one channel value, exact floor of the linear map
  function automatic logic [PixW-1:0] remap_level(input logic [PixW-1:0] v);
    int span_in;
    int span_out;
    int num;
    if (v <= lvl_cfg.in_low) return lvl_cfg.out_low;
    if (v >= lvl_cfg.in_high) return lvl_cfg.out_high;
    span_in  = int'(lvl_cfg.in_high) - int'(lvl_cfg.in_low);
    span_out = int'(lvl_cfg.out_high) - int'(lvl_cfg.out_low);
    num      = int'(lvl_cfg.out_low) * span_in + (int'(v) - int'(lvl_cfg.in_low)) * span_out;
    if (num < 0) num = 0;
    return PixW'(num / span_in);
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (remapped_q.size() == 0) begin
        $error("result beat with no pixel outstanding");
        mismatch_seen = 1'b1;
      end else begin
        want = remapped_q.pop_front();
        if (red_out_o !== want.red) begin
          $error("red_out: expected %0d, actual %0d", want.red, red_out_o);
          mismatch_seen = 1'b1;
        end
        if (green_out_o !== want.green) begin
          $error("green_out: expected %0d, actual %0d", want.green, green_out_o);
          mismatch_seen = 1'b1;
        end
        if (blue_out_o !== want.blue) begin
          $error("blue_out: expected %0d, actual %0d", want.blue, blue_out_o);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // one pixel beat, entered and left at a falling edge
  task automatic send_pixel(input logic [PixW-1:0] r, g, b);
    pixel_t want;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    want.red   = remap_level(r);
    want.green = remap_level(g);
    want.blue  = remap_level(b);
    remapped_q.push_back(want);
    @(negedge clk_i);
  endtask

  // one register write beat
  task automatic write_level(input logic [CfgIdxW-1:0] idx, input logic [PixW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegInLow:   lvl_cfg.in_low   = data;
      RegInHigh:  lvl_cfg.in_high  = data;
      RegOutLow:  lvl_cfg.out_low  = data;
      RegOutHigh: lvl_cfg.out_high = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // let the pipeline empty out
  task automatic drain_pixels();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (remapped_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // reprogram all four levels once the block is idle
  task automatic set_levels(input logic [PixW-1:0] il, ih, ol, oh);
    drain_pixels();
    write_level(RegInLow, il);
    write_level(RegInHigh, ih);
    write_level(RegOutLow, ol);
    write_level(RegOutHigh, oh);
  endtask

  // reset levels: empty input range at 130, dark 0, bright 255
  task automatic test_reset_levels();
    send_pixel(8'd0, 8'd129, 8'd130);
    send_pixel(8'd131, 8'd255, 8'd128);
  endtask

  // full range both ways is the identity
  task automatic test_identity_map();
    set_levels(8'd0, 8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd1, 8'd128);
    send_pixel(8'd254, 8'd255, 8'd127);
    send_pixel(8'h55, 8'hAA, 8'h0F);
  endtask

  // reversed output range gives a negative slope
  task automatic test_reversed_output();
    set_levels(8'd0, 8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd254);
    send_pixel(8'd255, 8'd100, 8'd200);
    set_levels(8'd40, 8'd200, 8'd230, 8'd17);
    send_pixel(8'd40, 8'd41, 8'd199);
    send_pixel(8'd200, 8'd120, 8'd0);
  endtask

  // empty or inverted input range never divides
  task automatic test_empty_input_range();
    set_levels(8'd200, 8'd50, 8'd10, 8'd240);
    send_pixel(8'd50, 8'd100, 8'd200);
    send_pixel(8'd201, 8'd0, 8'd255);
    set_levels(8'd0, 8'd0, 8'd77, 8'd33);
    send_pixel(8'd0, 8'd1, 8'd255);
    set_levels(8'd255, 8'd255, 8'd5, 8'd250);
    send_pixel(8'd255, 8'd254, 8'd0);
  endtask

  // smallest divisor, span of two
  task automatic test_narrow_span();
    set_levels(8'd100, 8'd102, 8'd0, 8'd255);
    send_pixel(8'd101, 8'd100, 8'd102);
    set_levels(8'd0, 8'd2, 8'd255, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd2);
    set_levels(8'd253, 8'd255, 8'd3, 8'd4);
    send_pixel(8'd254, 8'd255, 8'd253);
  endtask

  // channel value aimed at the levels most of the time
  function automatic logic [PixW-1:0] pick_channel();
    logic [PixW-1:0] lo;
    logic [PixW-1:0] hi;
    lo = lvl_cfg.in_low;
    hi = lvl_cfg.in_high;
    case ($urandom_range(4))
      0: return PixW'($urandom);
      1: return lo + PixW'($urandom_range(2)) - 8'd1;
      2: return hi + PixW'($urandom_range(2)) - 8'd1;
      default: begin
        if (hi > lo + 8'd1) return PixW'($urandom_range(int'(hi) - 1, int'(lo) + 1));
        return PixW'($urandom);
      end
    endcase
  endfunction

  // random levels, each held for a burst of random pixels
  task automatic test_random_levels(input int num_bursts, input int burst_len);
    logic [PixW-1:0] il;
    logic [PixW-1:0] ih;
    logic [PixW-1:0] ol;
    logic [PixW-1:0] oh;
    logic [PixW-1:0] t;
    for (int k = 0; k < num_bursts; k++) begin
      il = PixW'($urandom);
      ih = PixW'($urandom);
      case ($urandom_range(9))
        0: begin il = 8'd0; ih = 8'd255; end
        1: ih = il;
        2: if (il < ih) begin t = il; il = ih; ih = t; end
        3: begin il = PixW'($urandom_range(253)); ih = il + 8'd2; end
        default: if (il > ih) begin t = il; il = ih; ih = t; end
      endcase
      ol = PixW'($urandom);
      oh = PixW'($urandom);
      case ($urandom_range(5))
        0: begin ol = 8'd0; oh = 8'd255; end
        1: begin ol = 8'd255; oh = 8'd0; end
        default: ;
      endcase
      set_levels(il, ih, ol, oh);
      for (int n = 0; n < burst_len; n++) begin
        send_pixel(pick_channel(), pick_channel(), pick_channel());
      end
    end
  endtask

  // test sequence
  initial begin
    lvl_cfg.in_low   = RstInLow;
    lvl_cfg.in_high  = RstInHigh;
    lvl_cfg.out_low  = RstOutLow;
    lvl_cfg.out_high = RstOutHigh;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_levels();
    test_identity_map();
    test_reversed_output();
    test_empty_input_range();
    test_narrow_span();

    test_random_levels(8, 50);
    snd_idle_pct = 86;
    rcv_idle_pct = 24;
    test_random_levels(8, 50);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_levels(8, 50);

    drain_pixels();
    repeat (20) @(posedge clk_i);
    if (!mismatch_seen && remapped_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- rgb_levels_remap.f -----
src/rlr_pkg.sv
src/rlr_front.sv
src/rlr_div_cell.sv
src/rlr_back.sv
src/rgb_levels_remap.sv
src/rlr_checker.sv
tb/tb_rgb_levels_remap.sv
